@@ rtl/itoa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int VALUE_W     = 128;
	localparam int HALF_W      = 64;
	localparam int NIBBLE_W    = 4;
	localparam int TEXT_MAX    = 39;
	localparam int HEX_DIGITS  = VALUE_W / NIBBLE_W;
	localparam int DIGITS_W    = TEXT_MAX * NIBBLE_W;
	localparam int CONV_STEPS  = VALUE_W / NIBBLE_W;
	localparam int STEP_W      = $clog2(CONV_STEPS);
	localparam int LANE_CNT_W  = $clog2(TEXT_MAX + 1);
	localparam int LEN_W       = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_ALPHA = 8'h57;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [3:0] DEC_RADIX   = 4'd10;

	typedef enum logic [1:0] {
		OP_UDEC = 2'd0,
		OP_UHEX = 2'd1,
		OP_SDEC = 2'd2
	} op_t;

	typedef struct packed {
		logic               hex;
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

@@ rtl/itoa_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_front
// Accepts transactions and classifies them into conversion jobs.
// ----------------------------------------------------------------------------
module itoa_front (
	input  wire logic                        start,
	input  wire logic                        full,
	input  wire logic [1:0]                  op,
	input  wire logic [itoa_pkg::HALF_W-1:0] value_high,
	input  wire logic [itoa_pkg::HALF_W-1:0] value_low,
	output logic                             push,
	output itoa_pkg::job_t                   job
);
	import itoa_pkg::*;

	logic               valid_op;
	logic [HALF_W-1:0]  neg_low;

	assign neg_low = HALF_W'(0) - value_low;

	always_comb begin
		valid_op = 1'b1;
		job.hex  = 1'b0;
		job.neg  = 1'b0;
		job.mag  = {value_high, value_low};
		case (op_t'(op))
			OP_UDEC: begin
				job.mag = {value_high, value_low};
			end
			OP_UHEX: begin
				job.hex = 1'b1;
			end
			OP_SDEC: begin
				job.neg = value_low[HALF_W-1];
				job.mag = {{HALF_W{1'b0}}, value_low[HALF_W-1] ? neg_low : value_low};
			end
			default: begin
				valid_op = 1'b0;
			end
		endcase
	end

	assign push = start && !full && valid_op;

endmodule
`default_nettype wire

@@ rtl/itoa_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_queue
// Short job queue decoupling the front end from the conversion engine.
// ----------------------------------------------------------------------------
module itoa_queue #(
	parameter int DEPTH = itoa_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire itoa_pkg::job_t push_job,
	input  wire logic           pop,
	output logic                full,
	output logic                valid,
	output itoa_pkg::job_t      head
);
	import itoa_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign valid   = count_q != CW'(0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/itoa_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_back
// Conversion engine: shift-add-3 binary to BCD for decimal jobs, four bits a
// cycle, then leading-zero skip and most-significant-first character emission.
// ----------------------------------------------------------------------------
module itoa_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire itoa_pkg::job_t job,
	output logic                pop,
	output logic                strobe,
	output logic [7:0]          character,
	output logic                last,
	output logic [5:0]          length
);
	import itoa_pkg::*;

	state_t                state_q;
	state_t                state_d;
	logic [DIGITS_W-1:0]   dig_q;
	logic [VALUE_W-1:0]    bin_q;
	logic [STEP_W-1:0]     step_q;
	logic [LANE_CNT_W-1:0] rem_q;
	logic                  neg_q;
	logic                  started_q;
	logic [LEN_W-1:0]      len_q;

	logic [NIBBLE_W-1:0]   top;
	logic                  skip;
	logic                  emit;
	logic                  conv_done;
	logic [LEN_W-1:0]      first_len;

	function automatic logic [DIGITS_W-1:0] dabble(input logic [DIGITS_W-1:0] d,
		input logic [NIBBLE_W-1:0] b);
		logic [DIGITS_W-1:0] r;
		r = d;
		for (int i = NIBBLE_W - 1; i >= 0; i--) begin
			for (int k = 0; k < TEXT_MAX; k++) begin
				if (r[k*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
					r[k*NIBBLE_W +: NIBBLE_W] = r[k*NIBBLE_W +: NIBBLE_W] + 4'd3;
				end
			end
			r = {r[DIGITS_W-2:0], b[i]};
		end
		return r;
	endfunction

	assign top       = dig_q[DIGITS_W-1 -: NIBBLE_W];
	assign conv_done = step_q == STEP_W'(CONV_STEPS - 1);
	assign skip      = !started_q && (top == '0) && (rem_q > LANE_CNT_W'(1));
	assign first_len = LEN_W'(neg_q) + LEN_W'(rem_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = job.hex ? ST_EMIT : ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!skip && rem_q == LANE_CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		strobe    = 1'b0;
		character = ASCII_ZERO;
		last      = 1'b0;
		length    = '0;
		case (state_q)
			ST_IDLE: begin
				pop = job_valid;
			end
			ST_SIGN: begin
				strobe    = 1'b1;
				character = ASCII_MINUS;
			end
			ST_EMIT: begin
				emit      = !skip;
				strobe    = !skip;
				character = (top < DEC_RADIX) ? ASCII_ZERO + 8'(top) : ASCII_ALPHA + 8'(top);
				last      = !skip && rem_q == LANE_CNT_W'(1);
				if (last) begin
					length = started_q ? len_q : first_len;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					neg_q  <= job.neg;
					bin_q  <= job.mag;
					step_q <= '0;
					if (job.hex) begin
						dig_q <= {job.mag, {(DIGITS_W - VALUE_W){1'b0}}};
						rem_q <= LANE_CNT_W'(HEX_DIGITS);
					end else begin
						dig_q <= '0;
						rem_q <= LANE_CNT_W'(TEXT_MAX);
					end
				end
			end
			ST_CONV: begin
				dig_q  <= dabble(dig_q, bin_q[VALUE_W-1 -: NIBBLE_W]);
				bin_q  <= {bin_q[VALUE_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
				step_q <= step_q + STEP_W'(1);
			end
			ST_EMIT: begin
				dig_q <= {dig_q[DIGITS_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
				rem_q <= rem_q - LANE_CNT_W'(1);
				if (emit && !started_q) begin
					len_q <= first_len;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				started_q <= 1'b0;
			end else if (emit) begin
				started_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/integer_to_ascii_formatter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats an integer as ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy is high
// only while the job queue is full. Characters leave most significant first,
// one per cycle on strobe (save for skipped leading zeros), with last and
// length on the final one; the receiver cannot stall them. A selector of 3
// is taken and yields no text. Each decimal job passes through the
// shift-add-3 converter (four bits a cycle over the 128-bit word), then
// steps through the 39 digit lanes (leading zeros skipped, digits emitted),
// with a sign state for a negative job's minus and an idle state that pops
// the next job. Hex jobs skip the converter and step through 32 lanes. The
// front end keeps accepting while the engine works, until the queue fills.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top #(
	parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  op,
	input  wire logic [itoa_pkg::HALF_W-1:0] value_high,
	input  wire logic [itoa_pkg::HALF_W-1:0] value_low,
	output logic                             strobe,
	output logic [7:0]                       character,
	output logic                             last,
	output logic [5:0]                       length
);
	import itoa_pkg::*;

	logic full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head;

	assign busy = full;

	itoa_front u_front (
		.start      (start),
		.full       (full),
		.op         (op),
		.value_high (value_high),
		.value_low  (value_low),
		.push       (push),
		.job        (push_job)
	);

	itoa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (full),
		.valid    (head_valid),
		.head     (head)
	);

	itoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head),
		.pop       (pop),
		.strobe    (strobe),
		.character (character),
		.last      (last),
		.length    (length)
	);

endmodule
`default_nettype wire
